// File: rtl/core/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared widths, register indexes, pipeline tag type and the CORDIC and
// frequency-table constants of the sinusoidal timestep embedding.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int FREQ_ENTRIES  = 64;
    localparam int CORDIC_STAGES = 16;
    localparam int FREQ_AW       = (FREQ_ENTRIES > 1) ? $clog2(FREQ_ENTRIES) : 1;

    localparam int DIM_W      = 7;
    localparam int PERIOD_W   = 16;
    localparam int TS_W       = 24;
    localparam int FREQ_W     = 24;
    localparam int VAL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;

    localparam logic [DIM_W-1:0]    EMBED_DIM_RST  = 7'd64;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'd10000;

    // Angle path: Q12.12 times Q0.24 gives Q12.36, reduced modulo 2*pi.
    localparam int PROD_W    = TS_W + FREQ_W;
    localparam int MOD_STEPS = 10;
    localparam int REM_W     = 39;
    localparam logic [REM_W-1:0] TWO_PI_Q36 = 39'h6487ED5111;

    // CORDIC datapath, Q.30 in a signed word with headroom.
    localparam int ANG_W = 34;
    localparam int WRAP_W = ANG_W + 1;
    localparam logic signed [WRAP_W-1:0] PI_Q30      = 35'sh0C90FDAA2;
    localparam logic signed [WRAP_W-1:0] HALF_PI_Q30 = 35'sh06487ED51;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 35'sh1921FB544;
    localparam logic [ANG_W-1:0] QUARTER_PI_Q30 = 34'h03243F6A9;

    // Frequency-table build: log2 fraction bits and the Q0.32 root constants.
    localparam int LOG_FRAC = 24;
    localparam int LG_W     = 28;
    localparam int NUM_W    = 34;

    typedef struct packed {
        logic             valid;
        logic             pad;
        logic             last;
        logic [DIM_W-1:0] idx;
    } t_tag;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int s = 0; s < 32; s++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unsigned restoring division, used only to build constants.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(-2^-j) in Q0.32, each entry the truncated square root of the one before.
    function automatic logic [LOG_FRAC:0][31:0] root_tab();
        logic [LOG_FRAC:0][31:0] t;
        logic [63:0]             r;
        r    = 64'h8000_0000;
        t[0] = r[31:0];
        for (int j = 1; j <= LOG_FRAC; j++) begin
            r    = isqrt64({r[31:0], 32'h0});
            t[j] = r[31:0];
        end
        return t;
    endfunction

    // atan(2^-k) in Q.30 from the Taylor series in Q.40; k = 0 uses pi/4.
    function automatic logic [CORDIC_STAGES-1:0][ANG_W-1:0] atan_tab();
        logic [CORDIC_STAGES-1:0][ANG_W-1:0] t;
        longint acc;
        longint term;
        int     e;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (k == 0) begin
                t[k] = QUARTER_PI_Q30;
            end else begin
                acc = 0;
                for (int n = 0; n <= 40; n++) begin
                    e = k * (2 * n + 1);
                    if (e <= 40) begin
                        term = longint'(udiv64(64'd1 << (40 - e), 64'(2 * n + 1)));
                        acc  = (!n[0]) ? acc + term : acc - term;
                    end
                end
                t[k] = ANG_W'((acc + 512) >>> 10);
            end
        end
        return t;
    endfunction

    function automatic logic [ANG_W-1:0] gain_calc();
        logic [63:0] g;
        logic [63:0] s;
        g = 64'd1 << 30;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            s = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * k)));
            g = udiv64(g << 30, s);
        end
        return g[ANG_W-1:0];
    endfunction

    localparam logic [LOG_FRAC:0][31:0]             ROOT_HALF = root_tab();
    localparam logic [CORDIC_STAGES-1:0][ANG_W-1:0] ATAN_Q30  = atan_tab();
    localparam logic [ANG_W-1:0]                    GAIN_Q30  = gain_calc();

endpackage

// File: rtl/core/sinusoidal_timestep_embedding.sv
// ----------------------------------------------------------------------------
// sinusoidal_timestep_embedding
// Pipeline: issue register, product register, modulo-2*pi steps, angle
//   register, CORDIC stages, fold-back register and output register.
// Throughput: one beat per cycle while the output is not stalled; a
//   timestep holds the input until the single issue counter has issued its last beat.
// Reset: synchronous; afterwards, and after each register write, the
//   frequency table is rebuilt, during which input stalls.
// ----------------------------------------------------------------------------
module sinusoidal_timestep_embedding (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ste_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ste_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ste_pkg::TS_W-1:0]          i_timestep,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ste_pkg::DIM_W-1:0]         o_elem_index,
    output logic signed [ste_pkg::VAL_W-1:0]  o_even_value,
    output logic signed [ste_pkg::VAL_W-1:0]  o_odd_value,
    output logic                              o_odd_valid,
    output logic                              o_last
);
    import ste_pkg::*;

    // Control states. The first seven build the frequency table; IDLE waits
    // for a timestep and RUN issues one beat per cycle while the pipeline advances.
    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_LG   = 4'd2;
    localparam logic [3:0] ST_DSET = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_WR   = 4'd6;
    localparam logic [3:0] ST_IDLE = 4'd7;
    localparam logic [3:0] ST_RUN  = 4'd8;

    logic [3:0]          r_state;
    logic [DIM_W-1:0]    r_embed_dim;
    logic [PERIOD_W-1:0] r_max_period;

    // Table builder registers.
    logic [31:0]         r_y;
    logic [31:0]         r_sq;
    logic [LG_W-1:0]     r_lg;
    logic [NUM_W-1:0]    r_acc;
    logic [NUM_W-1:0]    r_num;
    logic [5:0]          r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [32:0]         r_p;
    logic [DIM_W-1:0]    r_ent;
    logic [5:0]          r_step;

    // Issue side.
    logic [DIM_W-1:0]    r_cnt;
    logic [TS_W-1:0]     r_ts;

    logic [FREQ_W-1:0]   r_mem [FREQ_ENTRIES];

    // Pipeline. Tags carry the valid bit and the beat's framing; the
    // payload registers next to them have no reset.
    t_tag                     r_s1_tag;
    logic [TS_W-1:0]          r_s1_ts;
    logic [FREQ_W-1:0]        r_freq;
    t_tag                     r_md_tag [MOD_STEPS+1];
    logic [PROD_W-1:0]        r_md_val [MOD_STEPS+1];
    t_tag                     r_rn_tag;
    logic signed [WRAP_W-1:0] r_rn_ang;
    t_tag                     r_cr_tag [CORDIC_STAGES+1];
    logic                     r_cr_neg [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0]  r_cx     [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0]  r_cy     [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0]  r_ca     [CORDIC_STAGES+1];
    t_tag                     r_fn_tag;
    logic signed [ANG_W-1:0]  r_fn_x;
    logic signed [ANG_W-1:0]  r_fn_y;

    logic                     r_out_valid;
    logic [DIM_W-1:0]         r_out_idx;
    logic signed [VAL_W-1:0]  r_out_even;
    logic signed [VAL_W-1:0]  r_out_odd;
    logic                     r_out_oddv;
    logic                     r_out_last;

    logic [5:0]          half;
    logic [DIM_W-1:0]    pairs;
    logic                pad_en;
    logic [PERIOD_W-1:0] mp_eff;
    logic [3:0]          msb;
    logic [31:0]         y_init;
    logic [63:0]         sq_prod;
    logic [6:0]          div_trial;
    logic [6:0]          div_diff;
    logic                div_ge;
    logic [64:0]         mul_prod;
    logic                mul_bit;
    logic [32:0]         wr_sh;
    logic [32:0]         wr_rnd;
    logic [FREQ_W-1:0]   wr_f;
    logic                adv;
    logic                cfg_hit;
    logic                iss_pair;
    t_tag                iss_tag;
    logic [REM_W:0]            rn_sum;
    logic signed [WRAP_W-1:0]  rn_a;
    logic signed [WRAP_W-1:0]  fd_a;
    logic                      fd_neg;

    function automatic logic signed [VAL_W-1:0] to_q15(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0]    s;
        logic signed [ANG_W-15:0] r;
        s = (ANG_W+1)'(v) + (ANG_W+1)'(16384);
        r = (ANG_W-14)'(s >>> 15);
        if (r > (ANG_W-14)'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -(ANG_W-14)'(32768)) begin
            return 16'sh8000;
        end
        return r[VAL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Derived configuration.
    // ------------------------------------------------------------------
    assign half   = r_embed_dim[DIM_W-1:1];
    assign pairs  = ({1'b0, half} < DIM_W'(FREQ_ENTRIES)) ? {1'b0, half} : DIM_W'(FREQ_ENTRIES);
    assign pad_en = r_embed_dim[0];
    assign mp_eff = (r_max_period == '0) ? PERIOD_W'(1) : r_max_period;

    always_comb begin
        msb = '0;
        for (int b = 0; b < PERIOD_W; b++) begin
            if (mp_eff[b]) msb = 4'(b);
        end
    end

    // Normalize the period so its leading one sits at bit 30 (Q.30 in [1,2)).
    assign y_init = {16'd0, mp_eff} << (5'd30 - {1'b0, msb});

    // One squaring per log2 fraction bit.
    assign sq_prod = 64'(r_y) * 64'(r_y);

    // Restoring division of lg*i + half/2 by half, one quotient bit a cycle.
    assign div_trial = {r_rem, r_num[NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, half};
    assign div_diff  = div_trial - {1'b0, half};

    // 2^-frac as a product of root constants, one factor a cycle.
    assign mul_prod = 65'(r_p) * 65'(ROOT_HALF[r_step[4:0]]);
    assign mul_bit  = r_quo[6'd24 - r_step];

    // Apply the integer part of the exponent, round to Q0.24 and saturate
    // (a unit frequency does not fit and becomes all ones).
    assign wr_sh  = r_p >> r_quo[LG_W-1:LOG_FRAC];
    assign wr_rnd = (wr_sh + 33'd128) >> 8;
    assign wr_f   = (wr_rnd > 33'h0FFFFFF) ? {FREQ_W{1'b1}} : wr_rnd[FREQ_W-1:0];

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_EMBED_DIM ||
                                  i_cfg_index == CFG_MAX_PERIOD);

    // The whole pipeline moves together whenever the output register is
    // free or being taken.
    assign adv = !r_out_valid || !i_out_stall;

    // Beat issued this cycle: a sin/cos pair while the counter is below the
    // pair count, then the zero pad beat when the dimension is odd.
    assign iss_pair = r_cnt < pairs;
    always_comb begin
        iss_tag.valid = (r_state == ST_RUN);
        iss_tag.pad   = !iss_pair;
        iss_tag.last  = iss_pair ? ((r_cnt == pairs - DIM_W'(1)) && !pad_en) : 1'b1;
        iss_tag.idx   = iss_pair ? {r_cnt[DIM_W-2:0], 1'b0} : r_embed_dim - DIM_W'(1);
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // Control: configuration, table build and issue sequencing.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_embed_dim  <= EMBED_DIM_RST;
            r_max_period <= MAX_PERIOD_RST;
            r_cnt        <= '0;
            r_ts         <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_EMBED_DIM) begin
                r_embed_dim <= i_cfg_data[DIM_W-1:0];
            end else begin
                r_max_period <= i_cfg_data[PERIOD_W-1:0];
            end
            r_state <= ST_INIT;
        end else begin
            case (r_state)
                ST_INIT: begin
                    r_y     <= y_init;
                    r_lg    <= {msb, {LOG_FRAC{1'b0}}};
                    r_step  <= 6'(LOG_FRAC - 1);
                    r_acc   <= '0;
                    r_ent   <= '0;
                    r_state <= (half == '0) ? ST_IDLE : ST_SQ;
                end
                ST_SQ: begin
                    r_sq    <= sq_prod[61:30];
                    r_state <= ST_LG;
                end
                ST_LG: begin
                    if (r_sq[31]) begin
                        r_y                <= {1'b0, r_sq[31:1]};
                        r_lg[r_step[4:0]]  <= 1'b1;
                    end else begin
                        r_y <= r_sq;
                    end
                    if (r_step == '0) begin
                        r_state <= ST_DSET;
                    end else begin
                        r_step  <= r_step - 6'd1;
                        r_state <= ST_SQ;
                    end
                end
                ST_DSET: begin
                    r_num   <= r_acc + NUM_W'(half >> 1);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_step  <= 6'(NUM_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= div_ge ? div_diff[5:0] : div_trial[5:0];
                    r_num <= r_num << 1;
                    r_quo <= {r_quo[NUM_W-2:0], div_ge};
                    if (r_step == '0) begin
                        r_step  <= 6'd1;
                        r_p     <= 33'h1_0000_0000;
                        r_state <= ST_MUL;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                ST_MUL: begin
                    if (mul_bit) r_p <= mul_prod[64:32];
                    if (r_step == 6'(LOG_FRAC)) begin
                        r_state <= ST_WR;
                    end else begin
                        r_step <= r_step + 6'd1;
                    end
                end
                ST_WR: begin
                    r_acc   <= r_acc + NUM_W'(r_lg);
                    r_ent   <= r_ent + DIM_W'(1);
                    r_state <= ((r_ent + DIM_W'(1)) == pairs) ? ST_IDLE : ST_DSET;
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_ts  <= i_timestep;
                        r_cnt <= '0;
                        if (pairs != '0) r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (adv) begin
                        if (iss_pair && ((r_cnt + DIM_W'(1) < pairs) || pad_en)) begin
                            r_cnt <= r_cnt + DIM_W'(1);
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

    // Frequency table memory: written by the builder, read by the issue stage.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_mem[r_ent[FREQ_AW-1:0]] <= wr_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_freq <= r_mem[r_cnt[FREQ_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Angle reduction and CORDIC pipeline.
    // ------------------------------------------------------------------
    assign rn_sum = {1'b0, r_md_val[MOD_STEPS][REM_W-1:0]} + (REM_W+1)'(32);
    assign rn_a   = {1'b0, rn_sum[REM_W:6]};

    // Fold into [-pi/2, pi/2]; the half turn is undone by negating x and y.
    always_comb begin
        fd_a   = r_rn_ang;
        fd_neg = 1'b0;
        if (r_rn_ang > HALF_PI_Q30) begin
            fd_a   = r_rn_ang - PI_Q30;
            fd_neg = 1'b1;
        end else if (r_rn_ang < -HALF_PI_Q30) begin
            fd_a   = r_rn_ang + PI_Q30;
            fd_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag    <= '0;
            r_rn_tag    <= '0;
            r_fn_tag    <= '0;
            r_out_valid <= 1'b0;
            for (int m = 0; m <= MOD_STEPS; m++) r_md_tag[m] <= '0;
            for (int k = 0; k <= CORDIC_STAGES; k++) r_cr_tag[k] <= '0;
        end else if (adv) begin
            r_s1_tag    <= iss_tag;
            r_md_tag[0] <= r_s1_tag;
            for (int m = 0; m < MOD_STEPS; m++) r_md_tag[m+1] <= r_md_tag[m];
            r_rn_tag    <= r_md_tag[MOD_STEPS];
            r_cr_tag[0] <= r_rn_tag;
            for (int k = 0; k < CORDIC_STAGES; k++) r_cr_tag[k+1] <= r_cr_tag[k];
            r_fn_tag    <= r_cr_tag[CORDIC_STAGES];
            r_out_valid <= r_fn_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ts     <= r_ts;
            r_md_val[0] <= PROD_W'(r_s1_ts) * PROD_W'(r_freq);
            // Modulo 2*pi by restoring subtraction of 2*pi << k, one k per stage.
            for (int m = 0; m < MOD_STEPS; m++) begin
                if (r_md_val[m] >= (PROD_W'(TWO_PI_Q36) << (MOD_STEPS - 1 - m))) begin
                    r_md_val[m+1] <= r_md_val[m] - (PROD_W'(TWO_PI_Q36) << (MOD_STEPS - 1 - m));
                end else begin
                    r_md_val[m+1] <= r_md_val[m];
                end
            end
            r_rn_ang    <= (rn_a > PI_Q30) ? rn_a - TWO_PI_Q30 : rn_a;
            r_cx[0]     <= signed'(GAIN_Q30);
            r_cy[0]     <= '0;
            r_ca[0]     <= ANG_W'(fd_a);
            r_cr_neg[0] <= fd_neg;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_cr_neg[k+1] <= r_cr_neg[k];
                if (!r_ca[k][ANG_W-1]) begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_ca[k+1] <= r_ca[k] - signed'(ATAN_Q30[k]);
                end else begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_ca[k+1] <= r_ca[k] + signed'(ATAN_Q30[k]);
                end
            end
            r_fn_x <= r_cr_neg[CORDIC_STAGES] ? -r_cx[CORDIC_STAGES] : r_cx[CORDIC_STAGES];
            r_fn_y <= r_cr_neg[CORDIC_STAGES] ? -r_cy[CORDIC_STAGES] : r_cy[CORDIC_STAGES];
            // Output register: round to Q1.15; the pad beat carries zeros.
            r_out_idx  <= r_fn_tag.idx;
            r_out_even <= r_fn_tag.pad ? '0 : to_q15(r_fn_y);
            r_out_odd  <= r_fn_tag.pad ? '0 : to_q15(r_fn_x);
            r_out_oddv <= !r_fn_tag.pad;
            r_out_last <= r_fn_tag.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_elem_index = r_out_idx;
    assign o_even_value = r_out_even;
    assign o_odd_value  = r_out_odd;
    assign o_odd_valid  = r_out_oddv;
    assign o_last       = r_out_last;

endmodule

// File: rtl/core/ste_checker.sv
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks on the timestep embedding, bound to the top level.
// ----------------------------------------------------------------------------
module ste_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [ste_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [ste_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [ste_pkg::TS_W-1:0]          i_timestep,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ste_pkg::DIM_W-1:0]         o_elem_index,
    input logic signed [ste_pkg::VAL_W-1:0]  o_even_value,
    input logic signed [ste_pkg::VAL_W-1:0]  o_odd_value,
    input logic                              o_odd_valid,
    input logic                              o_last
);
    import ste_pkg::*;

    // A register write starts a table rebuild, so no beat is taken right after.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == CFG_EMBED_DIM || i_cfg_index == CFG_MAX_PERIOD))
        |=> o_in_stall)
        else $error("input taken right after a register write");

    // The pad beat is zero and closes the timestep.
    a_pad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_odd_valid) |-> (o_even_value == '0 && o_odd_value == '0 && o_last))
        else $error("pad beat is not a zero final beat");

    // Pair beats start on even embedding indexes.
    a_pair_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_odd_valid) |-> !o_elem_index[0])
        else $error("pair beat on odd index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_elem_index) &&
            $stable(o_even_value) && $stable(o_odd_value) && $stable(o_last)))
        else $error("stalled output beat changed");

endmodule

bind sinusoidal_timestep_embedding ste_checker u_ste_checker (.*);
